### rtl/dq_pkg.sv
// Package for the double-ended queue: sizes, codes, item and control types.
`default_nettype none
package dq_pkg;

  localparam int DEPTH         = 1024;
  localparam int ADDR_W        = $clog2(DEPTH);
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int SUM_W         = ADDR_W + 2;
  localparam int WORD_W        = 32;
  localparam int COUNT_FIELD_W = 11;

  localparam logic signed [WORD_W-1:0] NEG_ONE = '1;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                      cmd;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  popped_value;
    logic                      pop_ok;
    logic                      overflow;
    logic [COUNT_FIELD_W-1:0]  count;
    logic                      is_empty;
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  back_value;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FORM
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic read_ends;
    logic form;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/double_ended_queue_core.sv
// Top level of the double-ended queue: sequencer plus ring datapath.
// After the edge that accepts an item, out_valid rises once the execute,
//   end-word read and result form steps are done; form waits while out_stall holds.
// A new item is taken only after the last one has formed its result, set by the single
//   ring memory's write-then-read sequence each item walks through.
// Reset (rst_n low, synchronous): queue empty, front pointer zero, no result
//   pending; ring contents are not cleared.
`default_nettype none
module double_ended_queue_core (
  input  wire                clk,
  input  wire                rst_n,
  // item channel
  input  wire                in_valid,
  output logic               in_stall,
  input  dq_pkg::in_item_t   in_item,
  // result channel
  output logic               out_valid,
  input  wire                out_stall,
  output dq_pkg::out_item_t  out_item
);

  // command/status between sequencer and datapath
  dq_pkg::ctrl_cmd_t ctrl_cmd;
  dq_pkg::dp_stat_t  dp_stat;

  // Sequencer: IDLE takes an item, EXEC updates pointers and writes the ring
  // (reading the popped word), READ fetches the new front and back words,
  // FORM loads the output register once it is free.
  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (ctrl_cmd),
    .stat     (dp_stat)
  );

  // Datapath: ring memory, front index, held count, output register.
  // The output register lets the next item start while a result waits.
  dq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctrl_cmd),
    .stat      (dp_stat),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

### rtl/dq_ctrl.sv
// Sequencer for the double-ended queue: steps one item through its phases.
`default_nettype none
module dq_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  output dq_pkg::ctrl_cmd_t   cmd,
  input  dq_pkg::dp_stat_t    stat
);

  dq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      dq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = dq_pkg::ST_EXEC;
        end
      end
      dq_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = dq_pkg::ST_READ;
      end
      dq_pkg::ST_READ: begin
        cmd.read_ends = 1'b1;
        state_nxt     = dq_pkg::ST_FORM;
      end
      dq_pkg::ST_FORM: begin
        // hold until the output register can take the result
        if (!stat.out_busy) begin
          cmd.form  = 1'b1;
          state_nxt = dq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/dq_datapath.sv
// Datapath for the double-ended queue: ring memory, pointers, output register.
`default_nettype none
module dq_datapath (
  input  wire                 clk,
  input  wire                 rst_n,
  input  dq_pkg::ctrl_cmd_t   cmd,
  output dq_pkg::dp_stat_t    stat,
  input  dq_pkg::in_item_t    in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output dq_pkg::out_item_t   out_item
);

  localparam logic [dq_pkg::ADDR_W-1:0] LAST_IDX = dq_pkg::ADDR_W'(dq_pkg::DEPTH - 1);
  localparam logic [dq_pkg::CNT_W-1:0]  FULL_CNT = dq_pkg::CNT_W'(dq_pkg::DEPTH);
  localparam logic [dq_pkg::SUM_W-1:0]  DEPTH_S  = dq_pkg::SUM_W'(dq_pkg::DEPTH);

  logic signed [dq_pkg::WORD_W-1:0] mem [dq_pkg::DEPTH];

  dq_pkg::in_item_t                 item_r;
  logic [dq_pkg::ADDR_W-1:0]        front_r;
  logic [dq_pkg::CNT_W-1:0]         count_r;
  logic                             pop_ok_r;
  logic                             ovf_r;
  logic signed [dq_pkg::WORD_W-1:0] popped_r;
  logic signed [dq_pkg::WORD_W-1:0] rd_a_r;
  logic signed [dq_pkg::WORD_W-1:0] rd_b_r;
  dq_pkg::out_item_t                out_r;
  logic                             out_valid_r;

  logic                             is_push;
  logic                             full;
  logic                             empty;
  logic [dq_pkg::ADDR_W-1:0]        front_dec;
  logic [dq_pkg::ADDR_W-1:0]        front_inc;
  logic [dq_pkg::SUM_W-1:0]         sum;
  logic [dq_pkg::SUM_W-1:0]         sum_m1;
  logic [dq_pkg::ADDR_W-1:0]        tail_pos;
  logic [dq_pkg::ADDR_W-1:0]        last_pos;
  logic [dq_pkg::ADDR_W-1:0]        wr_addr;
  logic [dq_pkg::ADDR_W-1:0]        rd_a_addr;
  logic                             wr_en;

  always_comb begin
    is_push   = (item_r.cmd == dq_pkg::OP_PUSH_FRONT) || (item_r.cmd == dq_pkg::OP_PUSH_BACK);
    full      = (count_r == FULL_CNT);
    empty     = (count_r == '0);
    front_dec = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
    front_inc = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
    // ring offsets: sum stays below 2*DEPTH, one compare-subtract wraps it
    sum       = dq_pkg::SUM_W'(front_r) + dq_pkg::SUM_W'(count_r);
    sum_m1    = sum - 1'b1;
    tail_pos  = (sum >= DEPTH_S) ? dq_pkg::ADDR_W'(sum - DEPTH_S)
                                 : dq_pkg::ADDR_W'(sum);
    last_pos  = (sum_m1 >= DEPTH_S) ? dq_pkg::ADDR_W'(sum_m1 - DEPTH_S)
                                    : dq_pkg::ADDR_W'(sum_m1);
    wr_addr   = (item_r.cmd == dq_pkg::OP_PUSH_FRONT) ? front_dec : tail_pos;
    wr_en     = cmd.exec && is_push && !full;
    // port A: popped slot during exec, front slot otherwise
    rd_a_addr = (cmd.exec && item_r.cmd == dq_pkg::OP_POP_BACK) ? last_pos : front_r;
  end

  // ring memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item_r.push_value;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[last_pos];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      if (is_push) begin
        if (!full) begin
          count_r <= count_r + 1'b1;
          if (item_r.cmd == dq_pkg::OP_PUSH_FRONT) begin
            front_r <= front_dec;
          end
        end
      end else if (!empty) begin
        count_r <= count_r - 1'b1;
        if (item_r.cmd == dq_pkg::OP_POP_FRONT) begin
          front_r <= front_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      ovf_r    <= is_push && full;
      pop_ok_r <= !is_push && !empty;
    end
    if (cmd.read_ends) begin
      popped_r <= pop_ok_r ? rd_a_r : dq_pkg::NEG_ONE;
    end
    if (cmd.form) begin
      out_r.popped_value <= popped_r;
      out_r.pop_ok       <= pop_ok_r;
      out_r.overflow     <= ovf_r;
      out_r.count        <= dq_pkg::COUNT_FIELD_W'(count_r);
      out_r.is_empty     <= empty;
      out_r.front_value  <= empty ? dq_pkg::NEG_ONE : rd_a_r;
      out_r.back_value   <= empty ? dq_pkg::NEG_ONE : rd_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.form) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_busy = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

endmodule
`default_nettype wire
